>>> rtl/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared constants, status codes and the command record passed from the
// parser to the copy engine.
// ----------------------------------------------------------------------------
package lzsd_pkg;

   localparam int WINDOW_BYTES   = 4096;
   localparam int OUT_LANE_BYTES = 8;

   localparam int ADDR_W  = $clog2(WINDOW_BYTES);
   localparam int LANE_W  = $clog2(OUT_LANE_BYTES + 1);
   localparam int OFF_W   = 13;   // offset after the plus-one, up to 4096
   localparam int LEN_W   = 9;    // match length, up to 273
   localparam int COUNT_W = 16;

   localparam logic [OFF_W-1:0] WIN_LIMIT = OFF_W'(WINDOW_BYTES);
   localparam logic [3:0]       LEN_EXT_CODE = 4'd15;
   localparam logic [LEN_W-1:0] LEN_BIAS     = 9'd3;
   localparam logic [LEN_W-1:0] LEN_EXT_BIAS = 9'd18;
   localparam logic [3:0]       GROUP_TOKENS = 4'd8;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_TRUNCATED = 2'd1;
   localparam logic [1:0] STAT_BAD_OFF   = 2'd2;
   localparam logic [1:0] STAT_EXCESS    = 2'd3;

   // One per accepted request. count is 0 for a request that yields no bytes.
   typedef struct packed {
      logic             is_copy;
      logic [7:0]       data;
      logic [11:0]      offset;     // offset minus one
      logic [LEN_W-1:0] count;
      logic             frame_last;
      logic [1:0]       status;
   } cmd_type;

endpackage

>>> rtl/lzsd_ram.sv
// ----------------------------------------------------------------------------
// lzsd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lzsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lzsd_front.sv
// ----------------------------------------------------------------------------
// lzsd_front
// Token parser: takes one compressed byte per request, tracks the frame
// state and turns each request into one command for the copy engine.
// ----------------------------------------------------------------------------
module lzsd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_last_byte,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_expected_length,
   input  logic              q_full,
   output logic              q_push,
   output lzsd_pkg::cmd_type q_cmd
);
   import lzsd_pkg::*;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_TOKEN,
      PH_OFFHI,
      PH_EXT
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] expect_ff;
   logic [COUNT_W-1:0] prod_ff, prod_in;
   logic [7:0]         flags_ff, flags_in;
   logic [3:0]         pos_ff, pos_in;
   logic [11:0]        off_ff, off_in;
   logic [1:0]         err_ff, err_in;

   logic               match_go;
   logic [LEN_W-1:0]   match_len;
   logic [OFF_W-1:0]   offset;
   logic [COUNT_W-1:0] room;
   logic [LEN_W-1:0]   take;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign q_push    = req_valid && req_ready;

   assign offset = {1'b0, off_in} + OFF_W'(1);
   assign room   = (prod_ff >= expect_ff) ? '0 : expect_ff - prod_ff;
   assign take   = ({7'd0, match_len} < room) ? match_len : room[LEN_W-1:0];

   always_comb begin
      phase_in  = phase_ff;
      prod_in   = prod_ff;
      flags_in  = flags_ff;
      pos_in    = pos_ff;
      off_in    = off_ff;
      err_in    = err_ff;
      match_go  = 1'b0;
      match_len = '0;
      q_cmd     = '0;
      q_cmd.data       = req_in_byte;
      q_cmd.frame_last = req_last_byte;

      if (err_ff == STAT_OK) begin
         if ((phase_ff == PH_FLAG || phase_ff == PH_TOKEN) && prod_ff >= expect_ff) begin
            err_in = STAT_EXCESS;
         end else begin
            case (phase_ff)
               PH_TOKEN: begin
                  if (!flags_ff[pos_ff[2:0]]) begin
                     q_cmd.count = LEN_W'(1);
                     prod_in     = prod_ff + COUNT_W'(1);
                     pos_in      = pos_ff + 4'd1;
                     phase_in    = (pos_in >= GROUP_TOKENS) ? PH_FLAG : PH_TOKEN;
                  end else begin
                     off_in   = {4'd0, req_in_byte};
                     phase_in = PH_OFFHI;
                  end
               end
               PH_OFFHI: begin
                  off_in = {req_in_byte[3:0], off_ff[7:0]};
                  if (req_in_byte[7:4] == LEN_EXT_CODE) begin
                     phase_in = PH_EXT;
                  end else begin
                     match_go  = 1'b1;
                     match_len = {5'd0, req_in_byte[7:4]} + LEN_BIAS;
                  end
               end
               PH_EXT: begin
                  match_go  = 1'b1;
                  match_len = {1'b0, req_in_byte} + LEN_EXT_BIAS;
               end
               default: begin
                  flags_in = req_in_byte;
                  pos_in   = '0;
                  phase_in = PH_TOKEN;
               end
            endcase

            if (match_go) begin
               if ({3'd0, offset} > prod_ff || offset > WIN_LIMIT) begin
                  err_in = STAT_BAD_OFF;
               end else begin
                  q_cmd.is_copy = 1'b1;
                  q_cmd.offset  = off_in;
                  q_cmd.count   = take;
                  prod_in       = prod_ff + {7'd0, take};
                  pos_in        = pos_ff + 4'd1;
                  phase_in      = (pos_in >= GROUP_TOKENS) ? PH_FLAG : PH_TOKEN;
               end
            end
         end
      end

      if (err_in != STAT_OK) begin
         q_cmd.status = err_in;
      end else if (phase_in == PH_OFFHI || phase_in == PH_EXT || prod_in < expect_ff) begin
         q_cmd.status = STAT_TRUNCATED;
      end else begin
         q_cmd.status = STAT_OK;
      end
      if (!req_last_byte) begin
         q_cmd.status = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FLAG;
         expect_ff <= '0;
         prod_ff   <= '0;
         flags_ff  <= '0;
         pos_ff    <= '0;
         off_ff    <= '0;
         err_ff    <= STAT_OK;
      end else begin
         if (csr_valid && csr_ready) begin
            expect_ff <= csr_expected_length;
         end
         if (q_push) begin
            if (req_last_byte) begin
               phase_ff <= PH_FLAG;
               prod_ff  <= '0;
               flags_ff <= '0;
               pos_ff   <= '0;
               off_ff   <= '0;
               err_ff   <= STAT_OK;
            end else begin
               phase_ff <= phase_in;
               prod_ff  <= prod_in;
               flags_ff <= flags_in;
               pos_ff   <= pos_in;
               off_ff   <= off_in;
               err_ff   <= err_in;
            end
         end
      end
   end

endmodule

>>> rtl/lzsd_queue.sv
// ----------------------------------------------------------------------------
// lzsd_queue
// Two-entry command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lzsd_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              head_valid,
   output lzsd_pkg::cmd_type head_cmd,
   input  logic              pop
);
   import lzsd_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> rtl/lzsd_back.sv
// ----------------------------------------------------------------------------
// lzsd_back
// Copy engine: writes literals into the history ring, copies matches from it
// one byte per cycle while the output register is not stalled, and packs decoded bytes into response words.
// ----------------------------------------------------------------------------
module lzsd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  lzsd_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [63:0]       rsp_out_bytes,
   output logic [3:0]        rsp_byte_count,
   output logic              rsp_run_last,
   output logic              rsp_frame_done,
   output logic [1:0]        rsp_status
);
   import lzsd_pkg::*;

   localparam int PACK_W = 8 * OUT_LANE_BYTES;

   typedef enum logic {
      ST_IDLE,
      ST_COPY
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]  src_ff, src_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic               pend_ff, pend_in;
   logic               fwd_ff, fwd_in;
   logic [7:0]         last_wr_ff;
   logic               cur_last_ff, cur_last_in;
   logic [1:0]         cur_status_ff, cur_status_in;
   logic [PACK_W-1:0]  pack_ff, pack_in;
   logic [LANE_W-1:0]  pk_cnt_ff, pk_cnt_in;
   logic               rsp_valid_ff;
   logic [63:0]        rsp_bytes_ff;
   logic [3:0]         rsp_count_ff;
   logic               rsp_run_last_ff;
   logic               rsp_frame_done_ff;
   logic [1:0]         rsp_status_ff;

   logic               adv;
   logic               put;
   logic               put_end;
   logic               empty_end;
   logic [7:0]         put_byte;
   logic               end_last;
   logic [1:0]         end_status;
   logic               emit;
   logic [PACK_W-1:0]  merged;
   logic               rd_en;
   logic [7:0]         rd_data;

   lzsd_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (put),
      .wr_addr (wr_ptr_ff),
      .wr_data (put_byte),
      .rd_en   (rd_en),
      .rd_addr (src_ff),
      .rd_data (rd_data)
   );

   assign adv = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      src_in        = src_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      fwd_in        = fwd_ff;
      cur_last_in   = cur_last_ff;
      cur_status_in = cur_status_ff;
      cmd_pop       = 1'b0;
      rd_en         = 1'b0;
      put           = 1'b0;
      put_end       = 1'b0;
      empty_end     = 1'b0;
      put_byte      = cmd.data;
      end_last      = cmd.frame_last;
      end_status    = cmd.status;

      case (state_ff)
         ST_COPY: begin
            end_last   = cur_last_ff;
            end_status = cur_status_ff;
            if (adv) begin
               if (pend_ff) begin
                  put      = 1'b1;
                  put_byte = fwd_ff ? last_wr_ff : rd_data;
                  put_end  = (left_ff == '0);
               end
               if (left_ff != '0) begin
                  rd_en   = 1'b1;
                  src_in  = src_ff + ADDR_W'(1);
                  left_in = left_ff - LEN_W'(1);
                  pend_in = 1'b1;
                  // offset of one reads the byte being written this cycle
                  fwd_in  = pend_ff && (src_ff == wr_ptr_ff);
               end else begin
                  pend_in  = 1'b0;
                  fwd_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            if (cmd_valid && adv) begin
               cmd_pop = 1'b1;
               if (cmd.count == '0) begin
                  empty_end = cmd.frame_last;
               end else if (!cmd.is_copy) begin
                  put     = 1'b1;
                  put_end = 1'b1;
               end else begin
                  src_in        = wr_ptr_ff - ADDR_W'(cmd.offset) - ADDR_W'(1);
                  left_in       = cmd.count;
                  pend_in       = 1'b0;
                  fwd_in        = 1'b0;
                  cur_last_in   = cmd.frame_last;
                  cur_status_in = cmd.status;
                  state_in      = ST_COPY;
               end
            end
         end
      endcase

      for (int i = 0; i < OUT_LANE_BYTES; i++) begin
         merged[8*i +: 8] = (pk_cnt_ff == LANE_W'(i)) ? put_byte : pack_ff[8*i +: 8];
      end

      emit = empty_end || (put && (put_end || pk_cnt_ff == LANE_W'(OUT_LANE_BYTES - 1)));

      pack_in   = pack_ff;
      pk_cnt_in = pk_cnt_ff;
      if (put) begin
         if (emit) begin
            pack_in   = '0;
            pk_cnt_in = '0;
         end else begin
            pack_in   = merged;
            pk_cnt_in = pk_cnt_ff + LANE_W'(1);
         end
      end

      // ring index restarts with every frame
      wr_ptr_in = put ? wr_ptr_ff + ADDR_W'(1) : wr_ptr_ff;
      if ((put_end || empty_end) && end_last) begin
         wr_ptr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (put) begin
         last_wr_ff <= put_byte;
      end
      if (emit) begin
         rsp_bytes_ff      <= empty_end ? '0 : 64'(merged);
         rsp_count_ff      <= empty_end ? 4'd0 : 4'(pk_cnt_ff) + 4'd1;
         rsp_run_last_ff   <= put_end || empty_end;
         rsp_frame_done_ff <= (put_end || empty_end) && end_last;
         rsp_status_ff     <= ((put_end || empty_end) && end_last) ? end_status : STAT_OK;
      end
      src_ff        <= src_in;
      left_ff       <= left_in;
      fwd_ff        <= fwd_in;
      cur_last_ff   <= cur_last_in;
      cur_status_ff <= cur_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         pack_ff      <= '0;
         pk_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         pend_ff      <= pend_in;
         pack_ff      <= pack_in;
         pk_cnt_ff    <= pk_cnt_in;
         rsp_valid_ff <= emit || (rsp_valid_ff && !rsp_ready);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_bytes  = rsp_bytes_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_run_last   = rsp_run_last_ff;
   assign rsp_frame_done = rsp_frame_done_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

>>> rtl/lzss_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS decoder with a 4 KiB history ring and packed byte output.
// ----------------------------------------------------------------------------
// Flag, offset, length and literal bytes are taken one per cycle while req_ready
// is high; a literal's byte passes through the command queue before it enters
// the ring and the packer. A match is copied through the single read port of
// the history ring, one byte per cycle while the output register can take it
// (overlapping copies included).
// A two-entry command queue lets the parser keep accepting requests during a
// copy until it fills, after which req_ready drops. Responses carry up to eight
// bytes and wait in an output register; a full output register stalls the copy
// engine. The ring needs no clearing after reset, so requests are taken from
// the first cycle out of reset. expected_length is written through csr_ and
// should only change between requests with nothing in flight.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_bytes,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_run_last,
   output logic        rsp_frame_done,
   output logic [1:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_expected_length
);
   import lzsd_pkg::*;

   logic    q_full;
   logic    q_push;
   cmd_type q_cmd;
   logic    head_valid;
   cmd_type head_cmd;
   logic    q_pop;

   lzsd_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .req_last_byte       (req_last_byte),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_expected_length (csr_expected_length),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_cmd               (q_cmd)
   );

   lzsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop)
   );

   lzsd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (head_valid),
      .cmd            (head_cmd),
      .cmd_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_bytes  (rsp_out_bytes),
      .rsp_byte_count (rsp_byte_count),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done),
      .rsp_status     (rsp_status)
   );

endmodule

>>> rtl/lzsd_checker.sv
// ----------------------------------------------------------------------------
// lzsd_checker
// Port-level checks on the response stream of the decompressor.
// ----------------------------------------------------------------------------
module lzsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_out_bytes,
   input logic [3:0]  rsp_byte_count,
   input logic        rsp_run_last,
   input logic        rsp_frame_done,
   input logic [1:0]  rsp_status
);
   import lzsd_pkg::*;

   // frame status only travels on the final word of a request
   a_done_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_run_last)
      else $error("frame_done without run_last");

   a_status_only_at_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_done |-> rsp_status == STAT_OK)
      else $error("status set outside frame end");

   a_empty_only_at_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count == 4'd0 |-> rsp_frame_done)
      else $error("empty response that does not close a frame");

   // a partly filled word must close its request
   a_partial_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_count != 4'(OUT_LANE_BYTES) |-> rsp_run_last)
      else $error("partial word in the middle of a request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_bytes)
         && $stable(rsp_byte_count))
      else $error("response changed while stalled");

endmodule

bind lzss_stream_decompressor lzsd_checker u_lzsd_checker (.*);
